// File: sv/nisqrt_pkg.sv
// Package for the Newton inverse square root unit: widths, constants, types.
// No dependencies.
package nisqrt_pkg;
    localparam int WordBits  = 32;
    localparam int FracBits  = 24;
    localparam int CountBits = 16;
    localparam int TolBits   = 16;
    localparam int CfgIdxBits = 2;

    localparam logic [CfgIdxBits-1:0] CfgCoef  = 2'd0;
    localparam logic [CfgIdxBits-1:0] CfgTol   = 2'd1;
    localparam logic [CfgIdxBits-1:0] CfgLimit = 2'd2;

    localparam logic [63:0] One    = 64'd1 << FracBits;
    localparam logic [63:0] Three  = 64'd3 << FracBits;
    localparam logic [63:0] MaxPos = (64'd1 << (WordBits - 1)) - 64'd1;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SQ, S_RES_A, S_RES_E, S_RES_CMP,
        S_T, S_Y, S_UPD, S_DONE
    } t_state;

    // Multiplier operand select for the shared multiplier.
    typedef struct packed {
        logic [63:0] p;
        logic [63:0] q;
    } t_mul_op;
endpackage

// File: sv/newton_inverse_sqrt_unit.sv
// Top level of the Newton inverse square root unit: config registers, sequencer.
// Depends on nisqrt_pkg and nisqrt_mul.
//
// Usage: write coefficient (index 0), tolerance (1) and iteration_limit (2)
// through the config channel; o_cfg_ready is low while an item is in flight.
// Raise start with i_initial_guess while busy is low; the item is taken at
// that edge and busy stays high until the result goes out. The result is on
// the output ports for one cycle with o_valid high; busy is already low in
// that cycle, so the next item may be taken there.
// Each Newton step uses the shared multiplier five times (x^2, a*u, e*u for
// the residual, a*u, x*d); each multiply holds the sequencer while the
// multiplier loads, forms four partial products and hands back the product.
// The residual test is skipped when x^2 rounds to zero. Results cannot be
// stalled; the receiver must take them as they come. Reset returns the
// config registers to their default values and the sequencer to idle.
// One item is in flight at a time.
module newton_inverse_sqrt_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [nisqrt_pkg::WordBits-1:0] i_initial_guess,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [nisqrt_pkg::CfgIdxBits-1:0]  i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    output logic                               o_valid,
    output logic signed [nisqrt_pkg::WordBits-1:0] o_estimate,
    output logic [nisqrt_pkg::CountBits-1:0]   o_step_count,
    output logic                               o_hit_limit,
    output logic                               o_overflowed
);
    import nisqrt_pkg::*;

    t_state r_state, n_state;
    logic [31:0]  r_coef;
    logic [15:0]  r_tol;
    logic [15:0]  r_limit;
    logic signed [63:0] r_x, r_last;
    logic         r_have_last, r_ovf, r_hit;
    logic [15:0]  r_steps;
    logic [63:0]  r_u, r_t;
    logic [127:0] r_au;
    logic         r_mwait;
    logic         w_mstart, w_mdone;
    t_mul_op      w_op;
    logic [127:0] w_prod;
    logic [63:0]  w_mx, w_dm, w_lim, w_y, w_diff;
    logic [127:0] w_rnd, w_one2;
    logic         w_dneg, w_neg, w_sat;
    logic [5:0]   w_sh;

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;

    // Configuration registers; hold them while an item is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= 32'h0400_0000;
            r_tol   <= 16'd2;
            r_limit <= 16'hFFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CfgCoef:  r_coef  <= i_cfg_data;
                CfgTol:   r_tol   <= i_cfg_data[15:0];
                CfgLimit: r_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign w_mx   = r_x[63] ? 64'd0 - r_x : r_x;
    assign w_dneg = r_t > Three;
    assign w_dm   = w_dneg ? r_t - Three : Three - r_t;
    assign w_neg  = r_x[63] != w_dneg;
    assign w_lim  = w_neg ? MaxPos + 64'd1 : MaxPos;
    assign w_diff = (r_x >= r_last) ? r_x - r_last : r_last - r_x;
    assign w_one2 = {64'd0, One} * {64'd0, One};

    // Round the product by the shift of the current multiply.
    assign w_sh  = (r_state == S_Y) ? 6'(FracBits + 1) : 6'(FracBits);
    assign w_rnd = (w_prod + (128'd1 << (w_sh - 6'd1))) >> w_sh;
    assign w_sat = (w_rnd[127:64] != 64'd0);
    assign w_y   = w_sat ? 64'hFFFF_FFFF_FFFF_FFFF : w_rnd[63:0];

    // Multiplier operand select.
    always_comb begin
        w_op.p = w_mx;
        w_op.q = w_mx;
        case (r_state)
            S_RES_A: begin w_op.p = {32'd0, r_coef}; w_op.q = r_u; end
            S_RES_E: begin w_op.p = {48'd0, r_tol};  w_op.q = r_u; end
            S_T:     begin w_op.p = {32'd0, r_coef}; w_op.q = r_u; end
            S_Y:     begin w_op.p = w_mx;            w_op.q = w_dm; end
            default: ;
        endcase
    end

    assign w_mstart = !r_mwait && (r_state == S_SQ || r_state == S_RES_A ||
                      r_state == S_RES_E || r_state == S_T || r_state == S_Y);

    nisqrt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_op    (w_op),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_CHECK;
            S_CHECK: begin
                if (r_steps == r_limit) n_state = S_DONE;
                else if (r_have_last && w_diff <= {48'd0, r_tol}) n_state = S_DONE;
                else n_state = S_SQ;
            end
            S_SQ:    if (w_mdone) n_state = (w_rnd[63:0] == 64'd0) ? S_T : S_RES_A;
            S_RES_A: if (w_mdone) n_state = S_RES_E;
            S_RES_E: if (w_mdone) n_state = S_RES_CMP;
            S_RES_CMP: n_state = S_T;
            S_T:     if (w_mdone) n_state = S_Y;
            S_Y:     if (w_mdone) n_state = S_UPD;
            S_UPD:   n_state = r_ovf ? S_DONE : S_CHECK;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_RES_CMP) begin
            // residual: au <= one2+eu and (one2 <= eu or one2-eu <= au)
            if (r_au <= w_one2 + {64'd0, r_t} &&
                (w_one2 <= {64'd0, r_t} || w_one2 - {64'd0, r_t} <= r_au))
                n_state = S_DONE;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mwait <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            if (w_mstart) r_mwait <= 1'b1;
            if (w_mdone)  r_mwait <= 1'b0;
            case (r_state)
                S_IDLE: if (start) begin
                    r_x         <= 64'(i_initial_guess);
                    r_steps     <= '0;
                    r_have_last <= 1'b0;
                    r_ovf       <= 1'b0;
                    r_hit       <= 1'b0;
                end
                S_CHECK: if (r_steps == r_limit) r_hit <= 1'b1;
                S_SQ:    if (w_mdone) r_u <= w_y;
                S_RES_A: if (w_mdone) r_au <= w_prod;
                S_RES_E: if (w_mdone) r_t <= w_prod[63:0];
                S_T:     if (w_mdone) begin
                    if (w_sat) r_ovf <= 1'b1;
                    r_t <= w_y;
                end
                S_Y: if (w_mdone) begin
                    r_last      <= r_x;
                    r_have_last <= 1'b1;
                    r_steps     <= r_steps + 16'd1;
                    if (w_sat || w_y > w_lim) begin
                        r_ovf <= 1'b1;
                        r_x   <= w_neg ? 64'd0 - w_lim : w_lim;
                    end else begin
                        r_x <= w_neg ? 64'd0 - w_y : w_y;
                    end
                end
                S_DONE: begin
                    o_valid      <= 1'b1;
                    o_estimate   <= r_x[WordBits-1:0];
                    o_step_count <= r_steps;
                    o_hit_limit  <= r_hit;
                    o_overflowed <= r_ovf;
                end
                default: ;
            endcase
        end
    end

    // Checks.
    a_valid_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_IDLE) else $error("result outside idle");
    a_steps_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_step_count <= r_limit) else $error("steps over limit");
endmodule

// File: sv/nisqrt_mul.sv
// Shared registered 64x64 multiplier used by the sequencer.
// Depends on nisqrt_pkg. Product is accumulated from four 32-bit partial products.
module nisqrt_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  nisqrt_pkg::t_mul_op  i_op,
    output logic                 o_done,
    output logic [127:0]         o_prod
);
    import nisqrt_pkg::*;

    logic [63:0]  r_p, r_q;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic [127:0] r_acc;
    logic [1:0]   w_ip, w_iq;
    logic [31:0]  w_pa, w_pb;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;

    assign w_ip = {1'b0, r_cnt[1]};
    assign w_iq = {1'b0, r_cnt[0]};

    // Pick one 32-bit half of each operand; one 32x32 product per cycle.
    assign w_pa = w_ip[0] ? r_p[63:32] : r_p[31:0];
    assign w_pb = w_iq[0] ? r_q[63:32] : r_q[31:0];
    assign w_pp = w_pa * w_pb;
    assign w_sh = {64'd0, w_pp} << (7'd32 * ({5'd0, w_ip} + {5'd0, w_iq}));

    // Accumulate one partial product per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_p    <= i_op.p;
                r_q    <= i_op.q;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= r_acc + w_sh;
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod = r_acc;
endmodule
